// File: design/assert_macros.svh
// Assertion macros used by the checker file.
// Needs a signal named clock and one named reset in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define FPS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define FPS_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

// File: design/fps_pkg.sv
// Shared constants for the farthest point sampling block.
// No dependencies.
package fps_pkg;
   localparam int MAX_POINTS_DEF  = 1024;
   localparam int COORD_WIDTH_DEF = 16;
   localparam int KEEP_W          = 7;
   localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd25;
   localparam logic [KEEP_W-1:0] KEEP_MAX   = 7'd64;
   localparam logic [KEEP_W-1:0] KEEP_MIN   = 7'd1;
   localparam int AXIS_X = 0;
   localparam int AXIS_Y = 1;
   localparam int AXIS_Z = 2;
endpackage

// File: design/fps_cell.sv
// One distance cell: squares the difference on its axis and accumulates.
// Depends on fps_pkg.
module fps_cell import fps_pkg::*; #(
   parameter int CW     = COORD_WIDTH_DEF,
   parameter int AXIS   = AXIS_X,
   parameter int IDX_W  = 10,
   parameter int ND_W   = 34
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [3*CW-1:0]     center_pt,
   input  logic                in_valid,
   input  logic [IDX_W-1:0]    in_idx,
   input  logic [3*CW-1:0]     in_pt,
   input  logic [ND_W-1:0]     in_nd,
   input  logic [2*CW+1:0]     in_sum,
   input  logic [2*CW+1:0]     in_sq,
   output logic                out_valid,
   output logic [IDX_W-1:0]    out_idx,
   output logic [3*CW-1:0]     out_pt,
   output logic [ND_W-1:0]     out_nd,
   output logic [2*CW+1:0]     out_sum,
   output logic [2*CW+1:0]     out_sq
);
   logic [CW-1:0]        a, b;
   logic signed [CW:0]   diff;
   logic [CW:0]          mag;
   logic [2*CW+1:0]      sq_in;
   logic                 valid_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [3*CW-1:0]      pt_ff;
   logic [ND_W-1:0]      nd_ff;
   logic [2*CW+1:0]      sum_ff, sq_ff;

   always_comb begin
      a     = center_pt[AXIS*CW +: CW];
      b     = in_pt[AXIS*CW +: CW];
      diff  = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
      mag   = diff[CW] ? (CW+1)'(-diff) : (CW+1)'(diff);
      sq_in = (2*CW+2)'(mag) * (2*CW+2)'(mag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      idx_ff <= in_idx;
      pt_ff  <= in_pt;
      nd_ff  <= in_nd;
      sum_ff <= in_sum + in_sq;
      sq_ff  <= sq_in;
   end

   assign out_valid = valid_ff;
   assign out_idx   = idx_ff;
   assign out_pt    = pt_ff;
   assign out_nd    = nd_ff;
   assign out_sum   = sum_ff;
   assign out_sq    = sq_ff;
endmodule

// File: design/farthest_point_sampling.sv
// Farthest point sampling: points load one beat per cycle into on-chip memory; the
// beat with final_point set closes the cloud. If the cloud holds more points than
// keep_count, each of keep_count-1 rounds (at least one) walks the remaining points
// through a chain of three axis cells (one memory read per cycle) and then swaps the
// winner into place. Results then leave one beat at a time, each read from memory and
// held until taken; no input is taken meanwhile.
// Depends on fps_pkg and fps_cell.
module farthest_point_sampling import fps_pkg::*; #(
   parameter int MAX_POINTS  = MAX_POINTS_DEF,
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_pos_x,
   input  logic signed [COORD_WIDTH-1:0] req_pos_y,
   input  logic signed [COORD_WIDTH-1:0] req_pos_z,
   input  logic                          req_final_point,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_WIDTH-1:0] rsp_out_x,
   output logic signed [COORD_WIDTH-1:0] rsp_out_y,
   output logic signed [COORD_WIDTH-1:0] rsp_out_z,
   output logic                          rsp_last_selected,
   input  logic                          csr_wr_en,
   input  logic [KEEP_W-1:0]             csr_wr_data
);
   localparam int CW     = COORD_WIDTH;
   localparam int PT_W   = 3*CW;
   localparam int SUM_W  = 2*CW+2;
   localparam int DIST_W = (SUM_W > 64) ? 64 : SUM_W;
   localparam int ADDR_W = $clog2(MAX_POINTS);
   localparam int CNT_W  = $clog2(MAX_POINTS+1);

   localparam logic [3:0] S_LOAD = 4'd0;
   localparam logic [3:0] S_CRD  = 4'd1;
   localparam logic [3:0] S_CWT  = 4'd2;
   localparam logic [3:0] S_WALK = 4'd3;
   localparam logic [3:0] S_SRD  = 4'd4;
   localparam logic [3:0] S_SWT  = 4'd5;
   localparam logic [3:0] S_SW2  = 4'd6;
   localparam logic [3:0] S_ERD  = 4'd7;
   localparam logic [3:0] S_EWT  = 4'd8;
   localparam logic [3:0] S_EOUT = 4'd9;

   logic [PT_W-1:0]   pt_mem [MAX_POINTS];
   logic [DIST_W-1:0] nd_mem [MAX_POINTS];

   logic [3:0]        state_ff, state_in;
   logic [KEEP_W-1:0] keep_ff, keep_eff;
   logic [CNT_W-1:0]  count_ff, count_in, n_ff, n_in, iss_ff, iss_in, cnt_inc;
   logic [KEEP_W-1:0] i_ff, i_in, j_ff, j_in, emit_ff, emit_in;
   logic [PT_W-1:0]   center_ff, center_in, tmp_pt_ff, tmp_pt_in;
   logic [DIST_W-1:0] tmp_nd_ff, tmp_nd_in;
   logic [DIST_W-1:0] best_ff, best_in;
   logic [ADDR_W-1:0] best_idx_ff, best_idx_in;
   logic [PT_W-1:0]   best_pt_ff, best_pt_in;
   logic              rsp_valid_ff, rsp_valid_in, last_ff, last_in;
   logic [PT_W-1:0]   rsp_pt_ff, rsp_pt_in;

   logic [ADDR_W-1:0] rd_addr;
   logic [PT_W-1:0]   rd_pt_ff;
   logic [DIST_W-1:0] rd_nd_ff;
   logic              rd_v_ff, rd_v_in;
   logic [ADDR_W-1:0] rd_idx_ff;

   logic              pw_en, nw_en;
   logic [ADDR_W-1:0] pw_addr, nw_addr;
   logic [PT_W-1:0]   pw_data;
   logic [DIST_W-1:0] nw_data;

   logic              c_v   [3];
   logic [ADDR_W-1:0] c_idx [3];
   logic [PT_W-1:0]   c_pt  [3];
   logic [DIST_W-1:0] c_nd  [3];
   logic [SUM_W-1:0]  c_sum [3];
   logic [SUM_W-1:0]  c_sq  [3];

   logic              f1_v_ff;
   logic [ADDR_W-1:0] f1_idx_ff;
   logic [PT_W-1:0]   f1_pt_ff;
   logic [DIST_W-1:0] f1_nd_ff;
   logic [SUM_W-1:0]  f1_sum_ff;
   logic [DIST_W-1:0] f1_dist, new_nd;
   logic              inflight, in_acc, full;

   fps_cell #(.CW(CW), .AXIS(AXIS_X), .IDX_W(ADDR_W), .ND_W(DIST_W)) u_cell_x (
      .clock, .reset, .center_pt(center_ff),
      .in_valid(rd_v_ff), .in_idx(rd_idx_ff), .in_pt(rd_pt_ff), .in_nd(rd_nd_ff),
      .in_sum('0), .in_sq('0),
      .out_valid(c_v[0]), .out_idx(c_idx[0]), .out_pt(c_pt[0]), .out_nd(c_nd[0]),
      .out_sum(c_sum[0]), .out_sq(c_sq[0]));

   fps_cell #(.CW(CW), .AXIS(AXIS_Y), .IDX_W(ADDR_W), .ND_W(DIST_W)) u_cell_y (
      .clock, .reset, .center_pt(center_ff),
      .in_valid(c_v[0]), .in_idx(c_idx[0]), .in_pt(c_pt[0]), .in_nd(c_nd[0]),
      .in_sum(c_sum[0]), .in_sq(c_sq[0]),
      .out_valid(c_v[1]), .out_idx(c_idx[1]), .out_pt(c_pt[1]), .out_nd(c_nd[1]),
      .out_sum(c_sum[1]), .out_sq(c_sq[1]));

   fps_cell #(.CW(CW), .AXIS(AXIS_Z), .IDX_W(ADDR_W), .ND_W(DIST_W)) u_cell_z (
      .clock, .reset, .center_pt(center_ff),
      .in_valid(c_v[1]), .in_idx(c_idx[1]), .in_pt(c_pt[1]), .in_nd(c_nd[1]),
      .in_sum(c_sum[1]), .in_sq(c_sq[1]),
      .out_valid(c_v[2]), .out_idx(c_idx[2]), .out_pt(c_pt[2]), .out_nd(c_nd[2]),
      .out_sum(c_sum[2]), .out_sq(c_sq[2]));

   always_comb begin
      keep_eff = keep_ff;
      if (keep_ff < KEEP_MIN) keep_eff = KEEP_MIN;
      if (keep_ff > KEEP_MAX) keep_eff = KEEP_MAX;
      f1_dist  = ((f1_sum_ff >> DIST_W) != '0) ? '1 : f1_sum_ff[DIST_W-1:0];
      new_nd   = ((i_ff == '0) || (f1_dist < f1_nd_ff)) ? f1_dist : f1_nd_ff;
      inflight = rd_v_ff | c_v[0] | c_v[1] | c_v[2] | f1_v_ff;
      in_acc   = req_valid && req_ready;
      full     = (32'(count_ff) >= MAX_POINTS);
      cnt_inc  = count_ff + 1'b1;
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      n_in        = n_ff;
      iss_in      = iss_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      emit_in     = emit_ff;
      center_in   = center_ff;
      tmp_pt_in   = tmp_pt_ff;
      tmp_nd_in   = tmp_nd_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      best_pt_in  = best_pt_ff;
      rsp_valid_in = rsp_valid_ff;
      last_in     = last_ff;
      rsp_pt_in   = rsp_pt_ff;
      rd_addr     = '0;
      rd_v_in     = 1'b0;
      pw_en       = 1'b0;
      pw_addr     = count_ff[ADDR_W-1:0];
      pw_data     = {req_pos_z, req_pos_y, req_pos_x};
      nw_en       = 1'b0;
      nw_addr     = f1_idx_ff;
      nw_data     = new_nd;

      if (f1_v_ff) begin
         nw_en = 1'b1;
         if (new_nd > best_ff) begin
            best_in     = new_nd;
            best_idx_in = f1_idx_ff;
            best_pt_in  = f1_pt_ff;
         end
      end

      case (state_ff)
         S_LOAD: begin
            if (in_acc) begin
               pw_en = !full;
               n_in  = full ? count_ff : cnt_inc;
               count_in = full ? count_ff : cnt_inc;
               if (req_final_point) begin
                  count_in = '0;
                  j_in     = '0;
                  i_in     = '0;
                  if (32'(n_in) <= 32'(keep_eff)) begin
                     emit_in  = KEEP_W'(n_in);
                     state_in = S_ERD;
                  end else begin
                     emit_in  = keep_eff;
                     state_in = S_CRD;
                  end
               end
            end
         end
         S_CRD: begin
            rd_addr  = ADDR_W'(i_ff);
            state_in = S_CWT;
         end
         S_CWT: begin
            center_in   = rd_pt_ff;
            iss_in      = CNT_W'(i_ff) + 1'b1;
            best_in     = '0;
            best_idx_in = '0;
            state_in    = S_WALK;
         end
         S_WALK: begin
            if (iss_ff < n_ff) begin
               rd_addr = iss_ff[ADDR_W-1:0];
               rd_v_in = 1'b1;
               iss_in  = iss_ff + 1'b1;
            end else if (!inflight) begin
               if (best_idx_ff != '0) begin
                  state_in = S_SRD;
               end else if (32'(i_ff) + 2 < 32'(emit_ff)) begin
                  i_in     = i_ff + 1'b1;
                  state_in = S_CRD;
               end else begin
                  state_in = S_ERD;
               end
            end
         end
         S_SRD: begin
            rd_addr  = ADDR_W'(i_ff + 1'b1);
            state_in = S_SWT;
         end
         S_SWT: begin
            tmp_pt_in = rd_pt_ff;
            tmp_nd_in = rd_nd_ff;
            pw_en     = 1'b1;
            pw_addr   = ADDR_W'(i_ff + 1'b1);
            pw_data   = best_pt_ff;
            nw_en     = 1'b1;
            nw_addr   = ADDR_W'(i_ff + 1'b1);
            nw_data   = best_ff;
            state_in  = S_SW2;
         end
         S_SW2: begin
            pw_en   = 1'b1;
            pw_addr = best_idx_ff;
            pw_data = tmp_pt_ff;
            nw_en   = 1'b1;
            nw_addr = best_idx_ff;
            nw_data = tmp_nd_ff;
            if (32'(i_ff) + 2 < 32'(emit_ff)) begin
               i_in     = i_ff + 1'b1;
               state_in = S_CRD;
            end else begin
               state_in = S_ERD;
            end
         end
         S_ERD: begin
            rd_addr  = ADDR_W'(j_ff);
            state_in = S_EWT;
         end
         S_EWT: begin
            rsp_pt_in    = rd_pt_ff;
            rsp_valid_in = 1'b1;
            last_in      = (32'(j_ff) + 1 == 32'(emit_ff));
            state_in     = S_EOUT;
         end
         S_EOUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               j_in         = j_ff + 1'b1;
               state_in     = last_ff ? S_LOAD : S_ERD;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pw_en) pt_mem[pw_addr] <= pw_data;
      if (nw_en) nd_mem[nw_addr] <= nw_data;
      rd_pt_ff <= pt_mem[rd_addr];
      rd_nd_ff <= nd_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         keep_ff      <= KEEP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_v_ff      <= 1'b0;
         f1_v_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) keep_ff <= csr_wr_data;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_v_ff      <= rd_v_in;
         f1_v_ff      <= c_v[2];
      end
      n_ff        <= n_in;
      iss_ff      <= iss_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      emit_ff     <= emit_in;
      center_ff   <= center_in;
      tmp_pt_ff   <= tmp_pt_in;
      tmp_nd_ff   <= tmp_nd_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      best_pt_ff  <= best_pt_in;
      last_ff     <= last_in;
      rsp_pt_ff   <= rsp_pt_in;
      rd_idx_ff   <= rd_addr;
      f1_idx_ff   <= c_idx[2];
      f1_pt_ff    <= c_pt[2];
      f1_nd_ff    <= c_nd[2];
      f1_sum_ff   <= c_sum[2] + c_sq[2];
   end

   assign req_ready         = (state_ff == S_LOAD);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_x         = rsp_pt_ff[0*CW +: CW];
   assign rsp_out_y         = rsp_pt_ff[1*CW +: CW];
   assign rsp_out_z         = rsp_pt_ff[2*CW +: CW];
   assign rsp_last_selected = last_ff;
endmodule

// File: design/fps_checker.sv
// Port-level checks for farthest_point_sampling, bound to the top level.
// Depends on fps_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fps_port_checker import fps_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [COORD_WIDTH-1:0] rsp_out_x,
   input logic                   rsp_last_selected
);
   `FPS_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_x), "rsp beat dropped or changed while stalled")
   `FPS_ASSERT_NOW(a_no_overlap, rsp_valid, !req_ready, "input taken while results pending")
   `FPS_ASSERT_NXT(a_last_reopens, rsp_valid && rsp_ready && rsp_last_selected, req_ready, "not ready after last result")
   `FPS_ASSERT_NXT(a_gap, rsp_valid && rsp_ready && !rsp_last_selected, !rsp_valid && !req_ready, "result beat pacing broken")
endmodule

bind farthest_point_sampling fps_port_checker #(.COORD_WIDTH(COORD_WIDTH)) u_fps_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready), .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready), .rsp_out_x(rsp_out_x), .rsp_last_selected(rsp_last_selected));
